[hdl/sbsm_pkg.sv]
// Shared types, constants and lookup table for the stereo balance, swap and mono unit
`timescale 1ns / 1ps

package sbsm_pkg;

    // sample and coefficient widths
    localparam int SAMPLE_BITS   = 24;
    localparam int COEF_BITS_DEF = 16;
    localparam int COEF_BITS_MAX = 24;

    // Q1.16 gain and mono amount
    localparam int GAIN_W = 17;
    localparam logic [GAIN_W-1:0] UNITY = 17'h10000;

    // smoothing pole after reset, Q0.16, cut to the coefficient width in use
    localparam logic [COEF_BITS_MAX-1:0] COEF_RESET = 24'd65481;

    // whole percent limit
    localparam logic [6:0] PCT_MAX = 7'd100;

    // register word indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MONO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd4;
    localparam int PADDR_W = CFG_IDX_W + 2;

    typedef logic [GAIN_W-1:0] q17_t;
    typedef q17_t [100:0] pct_table_t;

    // percent to Q1.16, round to nearest, built at elaboration
    function automatic pct_table_t build_pct_table();
        pct_table_t t;
        for (int i = 0; i <= 100; i++) begin
            t[i] = GAIN_W'((i * 65536 + 50) / 100);
        end
        return t;
    endfunction

    localparam pct_table_t PCT_Q16 = build_pct_table();

    // input and result beats
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
        logic                          frame_end;
    } sbsm_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          frame_end_out;
    } sbsm_out_t;

    // sequencer steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN_L,
        ST_GAIN_R,
        ST_MONO,
        ST_MONO_WB,
        ST_MIX_L,
        ST_MIX_R,
        ST_SCALE_L,
        ST_SCALE_R,
        ST_SCALE_WB,
        ST_DONE
    } sbsm_state_t;

endpackage

[hdl/stereo_balance_swap_mono_unit.sv]
// Stereo balance, channel swap and mono blend with one shared multiplier
`timescale 1ns / 1ps

// Usage
// s_ channel takes one stereo pair per beat (left_in, right_in, frame_end);
// m_ channel returns one processed pair per beat, frame_end copied across.
// Both use valid/ready; a beat moves when valid and ready are high together.
// Registers sit on the APB-style port at word addresses: balance, swap,
// mono, smoothing coefficient, enable. Write them only while the unit is idle.
// Active item: the result turns valid in the same cycle as s_ready comes back,
// so a new beat is taken only once the last result has left the sequencer; seven multiplies run in turn on one
// signed multiplier with a registered product, under an eleven-step sequencer.
// Disabled or transparent item: passes straight through, idle step to final step.
// s_ready is high only in the idle step. A finished result waits in the
// output register, so the next beat is taken while the receiver stalls;
// a second result holds in the final step until the output register empties.
// Reset (aresetn low, synchronous) restores the register defaults, unity
// gains and zero mono amount, and empties the unit.
module stereo_balance_swap_mono_unit #(
    parameter int COEF_BITS = sbsm_pkg::COEF_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beats
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sbsm_pkg::sbsm_in_t              s_data,
    // result beats
    output logic                            m_valid,
    input  logic                            m_ready,
    output sbsm_pkg::sbsm_out_t             m_data,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbsm_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    import sbsm_pkg::*;

    // multiplier operand and product widths
    localparam int MA = SAMPLE_BITS + 1;
    localparam int MB = (COEF_BITS > GAIN_W) ? COEF_BITS : GAIN_W;
    localparam int PW = MA + MB + 1;
    localparam int SW = SAMPLE_BITS;

    localparam logic [PW-1:0] HALF_C  = {{(PW-1){1'b0}}, 1'b1} << (COEF_BITS - 1);
    localparam logic [PW-1:0] HALF_17 = {{(PW-1){1'b0}}, 1'b1} << 16;
    localparam logic [PW-1:0] HALF_16 = {{(PW-1){1'b0}}, 1'b1} << 15;

    // configuration registers
    logic signed [7:0]      balance_reg;
    logic                   swap_reg;
    logic [6:0]             mono_pct_reg;
    logic [COEF_BITS-1:0]   coef_reg;
    logic                   enable_reg;

    // smoother state
    logic [GAIN_W-1:0]      gain_l_reg, gain_l_next;
    logic [GAIN_W-1:0]      gain_r_reg, gain_r_next;
    logic [GAIN_W-1:0]      mono_reg, mono_next;

    // sequencer and working registers
    sbsm_state_t            state_reg, state_next;
    logic signed [SW-1:0]   l_reg, l_next;
    logic signed [SW-1:0]   r_reg, r_next;
    logic                   fe_reg, fe_next;
    logic signed [PW-1:0]   p_reg, p_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    sbsm_out_t              m_data_reg, m_data_next;

    logic                   cfg_wr;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic                   s_take;
    logic                   out_load;

    logic                   bal_neg;
    logic [7:0]             bal_abs;
    logic [6:0]             bal_mag;
    logic [6:0]             mono_clamp;
    logic [GAIN_W-1:0]      bal_q;
    logic [GAIN_W-1:0]      tgt_l, tgt_r, tgt_m;
    logic                   transparent;
    logic                   active;

    logic signed [MA-1:0]   mul_a;
    logic [MB-1:0]          mul_b;
    logic signed [17:0]     gdiff;
    logic [GAIN_W-1:0]      g_now, g_tgt;
    logic signed [SW:0]     sdiff;

    logic signed [PW-1:0]   rnd_c, rnd_17, rnd_16;
    logic [GAIN_W:0]        glide_sum;
    logic [GAIN_W-1:0]      glide_val;
    logic signed [SW-1:0]   mix_val;
    logic signed [SW-1:0]   scale_val;

    // handshakes
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[PADDR_W-1:2];
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_take   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // register readback
    always_comb begin
        case (cfg_idx)
            REG_BALANCE: prdata = {24'd0, balance_reg};
            REG_SWAP:    prdata = {31'd0, swap_reg};
            REG_MONO:    prdata = {25'd0, mono_pct_reg};
            REG_COEF:    prdata = 32'(coef_reg);
            REG_ENABLE:  prdata = {31'd0, enable_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // clamp balance and mono to whole percent range
    always_comb begin
        bal_neg = balance_reg[7];
        bal_abs = bal_neg ? 8'(-balance_reg) : 8'(balance_reg);
        if (balance_reg > 8'sd100 || balance_reg < -8'sd100) begin
            bal_mag = PCT_MAX;
        end else begin
            bal_mag = bal_abs[6:0];
        end
        mono_clamp = (mono_pct_reg > PCT_MAX) ? PCT_MAX : mono_pct_reg;
    end

    // smoother targets, balance only attenuates the far side
    always_comb begin
        bal_q = PCT_Q16[bal_mag];
        tgt_l = bal_neg ? UNITY : UNITY - bal_q;
        tgt_r = bal_neg ? UNITY - bal_q : UNITY;
        tgt_m = PCT_Q16[mono_clamp];
    end

    assign transparent = (balance_reg == 8'sd0) && !swap_reg && (mono_pct_reg == 7'd0);
    assign active      = enable_reg && !transparent;

    // configuration writes, enable rising snaps the smoothers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            balance_reg  <= 8'sd0;
            swap_reg     <= 1'b0;
            mono_pct_reg <= 7'd0;
            coef_reg     <= COEF_RESET[COEF_BITS-1:0];
            enable_reg   <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BALANCE: balance_reg  <= signed'(pwdata[7:0]);
                REG_SWAP:    swap_reg     <= pwdata[0];
                REG_MONO:    mono_pct_reg <= pwdata[6:0];
                REG_COEF:    coef_reg     <= pwdata[COEF_BITS-1:0];
                REG_ENABLE:  enable_reg   <= pwdata[0];
                default:     ;
            endcase
        end
    end

    // next step of the sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    state_next = active ? ST_GAIN_L : ST_DONE;
                end
            end
            ST_GAIN_L:   state_next = ST_GAIN_R;
            ST_GAIN_R:   state_next = ST_MONO;
            ST_MONO:     state_next = ST_MONO_WB;
            ST_MONO_WB:  state_next = ST_MIX_L;
            ST_MIX_L:    state_next = ST_MIX_R;
            ST_MIX_R:    state_next = ST_SCALE_L;
            ST_SCALE_L:  state_next = ST_SCALE_R;
            ST_SCALE_R:  state_next = ST_SCALE_WB;
            ST_SCALE_WB: state_next = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // shared multiplier operands
    always_comb begin
        g_now = gain_l_reg;
        g_tgt = tgt_l;
        case (state_reg)
            ST_GAIN_R: begin
                g_now = gain_r_reg;
                g_tgt = tgt_r;
            end
            ST_MONO: begin
                g_now = mono_reg;
                g_tgt = tgt_m;
            end
            default: begin
                g_now = gain_l_reg;
                g_tgt = tgt_l;
            end
        endcase
        gdiff = signed'({1'b0, g_now}) - signed'({1'b0, g_tgt});
        sdiff = (state_reg == ST_MIX_R) ? (SW+1)'(l_reg) - (SW+1)'(r_reg)
                                        : (SW+1)'(r_reg) - (SW+1)'(l_reg);
        case (state_reg)
            ST_GAIN_L, ST_GAIN_R, ST_MONO: begin
                mul_a = {{(MA-18){gdiff[17]}}, gdiff};
                mul_b = MB'(coef_reg);
            end
            ST_MIX_L, ST_MIX_R: begin
                mul_a = sdiff;
                mul_b = MB'(mono_reg);
            end
            ST_SCALE_L: begin
                mul_a = MA'(l_reg);
                mul_b = MB'(gain_l_reg);
            end
            ST_SCALE_R: begin
                mul_a = MA'(r_reg);
                mul_b = MB'(gain_r_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        p_next = PW'(mul_a) * PW'(signed'({1'b0, mul_b}));
    end

    // round half up of the registered product
    always_comb begin
        rnd_c  = (p_reg + signed'(HALF_C)) >>> COEF_BITS;
        rnd_17 = (p_reg + signed'(HALF_17)) >>> 17;
        rnd_16 = (p_reg + signed'(HALF_16)) >>> 16;
    end

    // smoother write-back uses the target of the multiply whose product is now registered
    always_comb begin
        case (state_reg)
            ST_MONO:    glide_sum = {1'b0, tgt_r} + rnd_c[GAIN_W:0];
            ST_MONO_WB: glide_sum = {1'b0, tgt_m} + rnd_c[GAIN_W:0];
            default:    glide_sum = {1'b0, tgt_l} + rnd_c[GAIN_W:0];
        endcase
        glide_val = glide_sum[GAIN_W-1:0];
        mix_val   = (state_reg == ST_MIX_R) ? l_reg + rnd_17[SW-1:0]
                                            : r_reg + rnd_17[SW-1:0];
        scale_val = rnd_16[SW-1:0];
    end

    // datapath and output register updates per step
    always_comb begin
        gain_l_next  = gain_l_reg;
        gain_r_next  = gain_r_reg;
        mono_next    = mono_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        fe_next      = fe_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    fe_next = s_data.frame_end;
                    if (active && swap_reg) begin
                        l_next = s_data.right_in;
                        r_next = s_data.left_in;
                    end else begin
                        l_next = s_data.left_in;
                        r_next = s_data.right_in;
                    end
                end
            end
            ST_GAIN_R:   gain_l_next = glide_val;
            ST_MONO:     gain_r_next = glide_val;
            ST_MONO_WB:  mono_next   = glide_val;
            ST_MIX_R:    l_next      = mix_val;
            ST_SCALE_L:  r_next      = mix_val;
            ST_SCALE_R:  l_next      = scale_val;
            ST_SCALE_WB: r_next      = scale_val;
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next              = 1'b1;
                    m_data_next.left_out      = l_reg;
                    m_data_next.right_out     = r_reg;
                    m_data_next.frame_end_out = fe_reg;
                end
            end
            default: ;
        endcase
        if (cfg_wr && cfg_idx == REG_ENABLE && pwdata[0] && !enable_reg) begin
            gain_l_next = tgt_l;
            gain_r_next = tgt_r;
            mono_next   = tgt_m;
        end
    end

    // control and smoother state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            gain_l_reg  <= UNITY;
            gain_r_reg  <= UNITY;
            mono_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            gain_l_reg  <= gain_l_next;
            gain_r_reg  <= gain_r_next;
            mono_reg    <= mono_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        l_reg      <= l_next;
        r_reg      <= r_next;
        fe_reg     <= fe_next;
        p_reg      <= p_next;
        m_data_reg <= m_data_next;
    end

    // checks
    a_bypass_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_take && !active) |=> (state_reg == ST_DONE))
        else $error("bypass beat did not go straight to the final step");

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (gain_l_reg <= UNITY) && (gain_r_reg <= UNITY) && (mono_reg <= UNITY))
        else $error("smoother state above unity");

    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result beat raised outside the final step");

    a_done_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !m_valid_reg) |=> (state_reg == ST_IDLE && m_valid_reg))
        else $error("final step did not hand over to an empty output register");

endmodule
